@@ hw/rtl/ctc_pkg.sv @@
package ctc_pkg;

	// Bit positions within a channel control word.
	localparam int unsigned CW_IE         = 7;
	localparam int unsigned CW_COUNTER    = 6;
	localparam int unsigned CW_PRE256     = 5;
	localparam int unsigned CW_TC_FOLLOWS = 2;
	localparam int unsigned CW_RESET      = 1;
	localparam int unsigned CW_CONTROL    = 0;

	localparam logic [7:0] CW_RESET_VAL = 8'h23;
	localparam logic [7:0] CW_TC_CLEAR  = 8'h06;
	localparam logic [7:0] VEC_MASK     = 8'hF8;

	// Down counter width: 256 * 256 ticks must fit.
	localparam int unsigned CNT_W = 17;

	typedef enum logic [2:0] {
		FUNC_WRITE = 3'd0,
		FUNC_READ  = 3'd1,
		FUNC_TICK  = 3'd2,
		FUNC_PULSE = 3'd3,
		FUNC_ACK   = 3'd4,
		FUNC_RETI  = 3'd5
	} func_t;

	typedef struct packed {
		logic       tick;
		logic       pulse;
		logic       wr;
		logic       rd;
		logic [7:0] data;
	} chan_cmd_t;

	typedef struct packed {
		logic expired;
		logic ie;
		logic vec_wr;
	} chan_stat_t;

endpackage

@@ hw/rtl/ctc_channel.sv @@
module ctc_channel (
	input  logic               clk,
	input  logic               arst_n,
	input  ctc_pkg::chan_cmd_t cmd,
	output ctc_pkg::chan_stat_t stat,
	output logic [7:0]         rd_data
);
	import ctc_pkg::*;

	logic [7:0]       cw_q;
	logic [CNT_W-1:0] tc_q;
	logic [CNT_W-1:0] dc_q;
	logic [CNT_W-1:0] dec;
	logic [CNT_W-1:0] tc_new;
	logic [8:0]       n;
	logic             running;
	logic             count_en;
	logic             hit;

	assign running  = !cw_q[CW_RESET] && (tc_q != '0);
	assign count_en = running && ((cmd.tick && !cw_q[CW_COUNTER]) ||
		(cmd.pulse && cw_q[CW_COUNTER]));
	assign dec = dc_q - CNT_W'(1);
	assign hit = (dec == '0);

	// A time constant byte of zero stands for 256.
	assign n = (cmd.data == 8'd0) ? 9'd256 : {1'b0, cmd.data};

	always_comb begin
		if (cw_q[CW_COUNTER]) begin
			tc_new = {8'b0, n};
		end else if (cw_q[CW_PRE256]) begin
			tc_new = {n, 8'b0};
		end else begin
			tc_new = {4'b0, n, 4'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= CW_RESET_VAL;
			tc_q <= '0;
			dc_q <= '0;
		end else if (cmd.wr) begin
			if (cw_q[CW_TC_FOLLOWS]) begin
				cw_q <= cw_q & ~CW_TC_CLEAR;
				tc_q <= tc_new;
				dc_q <= tc_new;
			end else if (cmd.data[CW_CONTROL]) begin
				if (cmd.data[CW_RESET]) begin
					dc_q <= tc_q;
				end
				cw_q <= cmd.data;
			end
		end else if (count_en) begin
			dc_q <= hit ? tc_q : dec;
		end
	end

	assign stat.expired = count_en && hit;
	assign stat.ie      = cw_q[CW_IE];
	assign stat.vec_wr  = cmd.wr && !cw_q[CW_TC_FOLLOWS] && !cmd.data[CW_CONTROL];

	// Timer reads show the count in prescaler units.
	always_comb begin
		if (!cmd.rd || tc_q == '0) begin
			rd_data = 8'd0;
		end else if (cw_q[CW_COUNTER]) begin
			rd_data = dc_q[7:0];
		end else if (cw_q[CW_PRE256]) begin
			rd_data = dc_q[15:8];
		end else begin
			rd_data = dc_q[11:4];
		end
	end

endmodule

@@ hw/rtl/ctc_irq.sv @@
module ctc_irq #(
	parameter int unsigned NUM_CHANNELS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  ctc_pkg::func_t          func,
	input  logic [NUM_CHANNELS-1:0] exp,
	input  logic [NUM_CHANNELS-1:0] ie,
	input  logic                    vec_wr,
	input  logic [7:0]              vec_data,
	output logic [NUM_CHANNELS-1:0] pend_nxt,
	output logic [NUM_CHANNELS-1:0] act_nxt,
	output logic [7:0]              ack_vec
);
	import ctc_pkg::*;

	logic [NUM_CHANNELS-1:0] pend_q;
	logic [NUM_CHANNELS-1:0] act_q;
	logic [7:0]              vec_base_q;
	logic                    ack_hit;
	logic                    done;
	logic                    done_p;

	always_comb begin
		pend_nxt = pend_q;
		act_nxt  = act_q;
		ack_vec  = 8'd0;
		ack_hit  = 1'b0;
		done     = 1'b0;
		done_p   = 1'b0;
		unique case (func)
			FUNC_TICK, FUNC_PULSE: begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (exp[c]) begin
						pend_nxt[c] = ie[c];
					end
				end
			end
			FUNC_ACK: begin
				// Daisy chain: any active channel of equal or higher priority (lower number) blocks it.
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (!done) begin
						if (act_q[c]) begin
							done = 1'b1;
						end else if (pend_q[c]) begin
							done        = 1'b1;
							ack_hit     = 1'b1;
							pend_nxt[c] = 1'b0;
							act_nxt[c]  = 1'b1;
							ack_vec     = vec_base_q | {5'b0, 2'(c), 1'b0};
						end
					end
				end
			end
			FUNC_RETI: begin
				if (|act_q) begin
					for (int c = 0; c < NUM_CHANNELS; c++) begin
						if (!done && act_q[c]) begin
							done       = 1'b1;
							act_nxt[c] = 1'b0;
						end
					end
					// The first pending channel is dropped if its enable was withdrawn.
					for (int c = 0; c < NUM_CHANNELS; c++) begin
						if (!done_p && pend_q[c]) begin
							done_p      = 1'b1;
							pend_nxt[c] = ie[c];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			act_q      <= '0;
			vec_base_q <= 8'd0;
		end else if (en) begin
			pend_q <= pend_nxt;
			act_q  <= act_nxt;
			if (vec_wr) begin
				vec_base_q <= vec_data & VEC_MASK;
			end
		end
	end

	a_ack_adds_one: assert property (@(posedge clk) disable iff (!arst_n)
		en && func == FUNC_ACK && ack_hit |=>
		$countones(act_q) == $countones($past(act_q)) + 1)
		else $error("acknowledge did not add exactly one active channel");

	a_reti_drops_one: assert property (@(posedge clk) disable iff (!arst_n)
		en && func == FUNC_RETI && (|act_q) |=>
		$countones(act_q) + 1 == $countones($past(act_q)))
		else $error("return from interrupt did not end exactly one service");

	a_count_keeps_active: assert property (@(posedge clk) disable iff (!arst_n)
		en && (func == FUNC_TICK || func == FUNC_PULSE) |=> act_q == $past(act_q))
		else $error("counting changed the active set");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> pend_q == $past(pend_q) && act_q == $past(act_q))
		else $error("interrupt state changed without a beat");

endmodule

@@ hw/rtl/counter_timer_channels_core.sv @@
// Four-channel counter/timer in the style of the classic CTC.
// Input channel (in_valid/in_ready) carries one operation per beat: func selects
// write, read, clock tick, trigger pulse, interrupt acknowledge or return from
// interrupt; channel and write_data qualify it. Output channel
// (out_valid/out_ready) returns exactly one beat per input beat, in order:
// read_data (count on read, vector on acknowledge, else zero) and the pending,
// active and expired channel masks as they stand after the operation.
// An accepted beat is held in the input register, where the channel and
// interrupt logic update the state and load the result register once the
// result register is free or its beat is being taken.
// Throughput is one operation per cycle while the receiver keeps up; the state
// update in the per-channel counters and the interrupt priority logic sets that figure.
// When the receiver stalls, the result register holds and one further operation
// is taken into the input register; in_ready then drops until out_ready returns.
// Reset (arst_n low) sets every control word to 0x23, clears time constants,
// counts, interrupt state and vector base, and empties both registers.
module counter_timer_channels_core #(
	parameter int unsigned NUM_CHANNELS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] func,
	input  logic [1:0] channel,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [3:0] pending_mask,
	output logic [3:0] active_mask,
	output logic [3:0] expired_mask
);
	import ctc_pkg::*;

	logic        valid_s1;
	func_t       func_s1;
	logic [1:0]  channel_s1;
	logic [7:0]  data_s1;
	logic        adv;
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic [3:0]  pending_q;
	logic [3:0]  active_q;
	logic [3:0]  expired_q;

	chan_cmd_t               cmd   [NUM_CHANNELS];
	chan_stat_t              stat  [NUM_CHANNELS];
	logic [7:0]              rd_ch [NUM_CHANNELS];
	logic [7:0]              rd_or;
	logic [7:0]              ack_vec;
	logic [7:0]              rd_nxt;
	logic [NUM_CHANNELS-1:0] exp_vec;
	logic [NUM_CHANNELS-1:0] ie_vec;
	logic [NUM_CHANNELS-1:0] pend_nxt;
	logic [NUM_CHANNELS-1:0] act_nxt;

	// The held operation moves on whenever the result register is free or being taken.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1    <= func_t'(func);
			channel_s1 <= channel;
			data_s1    <= write_data;
		end
	end

	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
		logic sel;

		assign sel = (channel_s1 == 2'(g));
		assign cmd[g].tick  = adv && func_s1 == FUNC_TICK;
		assign cmd[g].pulse = adv && sel && func_s1 == FUNC_PULSE;
		assign cmd[g].wr    = adv && sel && func_s1 == FUNC_WRITE;
		assign cmd[g].rd    = sel && func_s1 == FUNC_READ;
		assign cmd[g].data  = data_s1;

		ctc_channel u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd[g]),
			.stat    (stat[g]),
			.rd_data (rd_ch[g])
		);

		assign exp_vec[g] = stat[g].expired;
		assign ie_vec[g]  = stat[g].ie;
	end

	always_comb begin
		rd_or = 8'd0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			rd_or = rd_or | rd_ch[c];
		end
	end

	ctc_irq #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_irq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.func     (func_s1),
		.exp      (exp_vec),
		.ie       (ie_vec),
		.vec_wr   (stat[0].vec_wr),
		.vec_data (data_s1),
		.pend_nxt (pend_nxt),
		.act_nxt  (act_nxt),
		.ack_vec  (ack_vec)
	);

	always_comb begin
		unique case (func_s1)
			FUNC_READ: rd_nxt = rd_or;
			FUNC_ACK:  rd_nxt = ack_vec;
			default:   rd_nxt = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= rd_nxt;
			pending_q   <= 4'(pend_nxt);
			active_q    <= 4'(act_nxt);
			expired_q   <= 4'(exp_vec);
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign pending_mask = pending_q;
	assign active_mask  = active_q;
	assign expired_mask = expired_q;

endmodule
